>>> sv/bdel_pkg.sv
// bdel_pkg: shared types, codes and defaults of the bounded double-ended list
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package bdel_pkg;

    localparam int DEF_CAPACITY    = 256;
    localparam int DEF_ENTRY_WIDTH = 32;
    localparam int MAX_ENTRY_W     = 64;
    localparam int ENTRY_IN_W      = 32;
    localparam int READ_W          = 32;
    localparam int POS_W           = 8;
    localparam int CMD_W           = 3;
    localparam int STS_W           = 2;
    localparam int IN_TDATA_W      = 40;
    localparam int QDEPTH          = 4;
    localparam int QAW             = $clog2(QDEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_RM_HEAD  = 3'd2,
        CMD_RM_TAIL  = 3'd3,
        CMD_RD_HEAD  = 3'd4,
        CMD_RD_TAIL  = 3'd5,
        CMD_RD_INDEX = 3'd6,
        CMD_SIZE     = 3'd7
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RESP = 1'b1
    } back_state_t;

    // classified request as it travels from front to back
    typedef struct packed {
        cmd_t             op;
        logic             ins;
        logic             rem;
        logic             rd;
        logic             at_tail;
        logic [POS_W-1:0] pos;
    } req_t;

endpackage

>>> sv/bdel_front.sv
// bdel_front: takes requests off the input stream and classifies them
// depends on bdel_pkg
`timescale 1ns / 1ps

module bdel_front import bdel_pkg::*; #(
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // entry_data[31:0], position[39:32]
    input  logic [CMD_W-1:0]       s_tuser,   // command[2:0]
    input  logic                   q_full,
    output logic                   q_push,
    output req_t                   q_req,
    output logic [ENTRY_WIDTH-1:0] q_data
);

    logic [MAX_ENTRY_W-1:0] data_wide;
    cmd_t                   op;

    assign op       = cmd_t'(s_tuser);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        data_wide = '0;
        data_wide[ENTRY_IN_W-1:0] = s_tdata[ENTRY_IN_W-1:0];
        q_data = data_wide[ENTRY_WIDTH-1:0];
    end

    always_comb
    begin
        q_req.op      = op;
        q_req.pos     = s_tdata[ENTRY_IN_W +: POS_W];
        q_req.ins     = 1'b0;
        q_req.rem     = 1'b0;
        q_req.rd      = 1'b0;
        q_req.at_tail = 1'b0;
        case (op)
            CMD_INS_HEAD: q_req.ins = 1'b1;
            CMD_INS_TAIL:
            begin
                q_req.ins     = 1'b1;
                q_req.at_tail = 1'b1;
            end
            CMD_RM_HEAD:  q_req.rem = 1'b1;
            CMD_RM_TAIL:
            begin
                q_req.rem     = 1'b1;
                q_req.at_tail = 1'b1;
            end
            CMD_RD_HEAD:  q_req.rd = 1'b1;
            CMD_RD_TAIL:
            begin
                q_req.rd      = 1'b1;
                q_req.at_tail = 1'b1;
            end
            CMD_RD_INDEX: q_req.rd = 1'b1;
            default: ;
        endcase
    end

endmodule

>>> sv/bdel_queue.sv
// bdel_queue: short request queue between front and back
// depends on bdel_pkg
`timescale 1ns / 1ps

module bdel_queue import bdel_pkg::*; #(
    parameter int DATA_W = DEF_ENTRY_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  req_t              push_req,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output req_t              head_req,
    output logic [DATA_W-1:0] head_data
);

    req_t              req_mem_reg  [QDEPTH];
    logic [DATA_W-1:0] data_mem_reg [QDEPTH];
    logic [QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]      fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full      = (fill_reg == (QAW+1)'(QDEPTH));
    assign valid     = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;
    assign head_req  = req_mem_reg[rd_ptr_reg];
    assign head_data = data_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + (QAW+1)'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - (QAW+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            req_mem_reg[wr_ptr_reg]  <= push_req;
            data_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/bdel_back.sv
// bdel_back: carries out list requests on the circular store and drives results
// depends on bdel_pkg
`timescale 1ns / 1ps

module bdel_back import bdel_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  req_t                   q_req,
    input  logic [ENTRY_WIDTH-1:0] q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [((READ_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [STS_W-1:0]       m_tuser
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int MW    = (CW > POS_W) ? CW : POS_W;
    localparam int SW    = CW + 1;
    localparam int OUT_W = ((READ_W + CW + 7) / 8) * 8;

    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0] mem_q_reg;

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    status_t           sts_reg, sts_next;
    logic              rdok_reg, rdok_next;
    logic              m_valid_reg, m_valid_next;
    logic [READ_W-1:0] m_data_reg, m_data_next;
    logic [CW-1:0]     m_cnt_reg, m_cnt_next;
    status_t           m_sts_reg, m_sts_next;

    logic                   empty, full;
    logic [CW-1:0]          offset;
    logic [SW-1:0]          sum, sum_wrap;
    logic [AW-1:0]          slot, head_dec, addr;
    logic [MW-1:0]          pos_wide, cnt_wide;
    logic                   wr_en;
    logic [MAX_ENTRY_W-1:0] rd_wide;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(CAPACITY));
    assign pos_wide = MW'(q_req.pos);
    assign cnt_wide = MW'(count_reg);
    assign q_pop    = (state_reg == BK_IDLE) && q_valid;

    // physical slot of an offset from the head; the offset stays below capacity only for commands that are carried out
    always_comb
    begin
        case (q_req.op)
            CMD_INS_TAIL: offset = count_reg;
            CMD_RD_TAIL:  offset = count_reg - CW'(1);
            CMD_RM_HEAD:  offset = CW'(1);
            CMD_RD_INDEX: offset = pos_wide[CW-1:0];
            default:      offset = '0;
        endcase
        sum      = SW'(head_reg) + SW'(offset);
        sum_wrap = (sum >= SW'(CAPACITY)) ? sum - SW'(CAPACITY) : sum;
        slot     = sum_wrap[AW-1:0];
        head_dec = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
        addr     = (q_req.op == CMD_INS_HEAD) ? head_dec : slot;
    end

    always_comb
    begin
        rd_wide = '0;
        rd_wide[ENTRY_WIDTH-1:0] = mem_q_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        sts_next     = sts_reg;
        rdok_next    = rdok_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_cnt_next   = m_cnt_reg;
        m_sts_next   = m_sts_reg;
        wr_en        = 1'b0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_RESP;
                    sts_next   = STS_OK;
                    rdok_next  = 1'b0;
                    if (q_req.ins)
                    begin
                        if (full)
                            sts_next = STS_FULL;
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (!q_req.at_tail)
                                head_next = head_dec;
                        end
                    end
                    else if (q_req.rem)
                    begin
                        if (empty)
                            sts_next = STS_EMPTY;
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            if (!q_req.at_tail)
                                head_next = slot;
                        end
                    end
                    else if (q_req.rd)
                    begin
                        if (empty)
                            sts_next = STS_EMPTY;
                        else if (q_req.op == CMD_RD_INDEX && pos_wide >= cnt_wide)
                            sts_next = STS_RANGE;
                        else
                            rdok_next = 1'b1;
                    end
                end
            end
            BK_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next   = BK_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = rdok_reg ? rd_wide[READ_W-1:0] : '0;
                    m_cnt_next   = count_reg;
                    m_sts_next   = sts_reg;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sts_reg    <= sts_next;
        rdok_reg   <= rdok_next;
        m_data_reg <= m_data_next;
        m_cnt_reg  <= m_cnt_next;
        m_sts_reg  <= m_sts_next;
    end

    // read word is held until the result phase hands it over
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= q_data;
        if (q_pop)
            mem_q_reg <= mem[addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_cnt_reg, m_data_reg});
    assign m_tuser  = m_sts_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_req.ins && !full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted insert did not grow the count");

    a_pop_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == BK_RESP)
        else $error("request taken without a result phase");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_sts_reg != STS_OK) |-> m_data_reg == '0)
        else $error("failed request returned nonzero data");

endmodule

>>> sv/bounded_double_ended_list_core.sv
// bounded_double_ended_list_core: top level of the bounded double-ended list
// depends on bdel_pkg, bdel_front, bdel_queue, bdel_back
`timescale 1ns / 1ps

// Bounded double-ended list with indexed read. Each request on the s_ stream
// carries one command (insert head/tail, remove head/tail, read head/tail,
// read at position, report size) and produces exactly one result on the m_
// stream with the read word, the entry count after the command and a status
// (ok, full insert ignored, empty, position beyond count). Entries live in a
// circular store of CAPACITY words addressed from a head pointer, so every
// command is a single memory access. The back end accesses the store when it
// takes a request in its idle state, then in its result state moves the
// registered read data into the output register once that register is free,
// and takes no new request before that. A four-deep request queue sits
// between the front end and the back end, so requests keep being accepted
// while a result waits on m_tready. After reset the list is empty and ready at once; no clearing pass runs.

module bounded_double_ended_list_core import bdel_pkg::*; #(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // entry_data[31:0], position[39:32]
    input  logic [CMD_W-1:0]      s_tuser,   // command[2:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data[31:0], count[32 +: clog2(CAPACITY+1)], zero fill to bytes
    output logic [((READ_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic [STS_W-1:0]      m_tuser    // status[1:0]
);

    // front to queue
    logic                   push;
    req_t                   push_req;
    logic [ENTRY_WIDTH-1:0] push_data;
    logic                   q_full;

    // queue to back
    logic                   q_valid;
    logic                   q_pop;
    req_t                   head_req;
    logic [ENTRY_WIDTH-1:0] head_data;

    // decode commands and mask the entry word to the stored width
    bdel_front #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (push),
        .q_req    (push_req),
        .q_data   (push_data)
    );

    // decouples request intake from the store
    bdel_queue #(
        .DATA_W (ENTRY_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_req  (head_req),
        .head_data (head_data)
    );

    // circular store, head pointer, count and output register
    bdel_back #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_req    (head_req),
        .q_data   (head_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> verif/bdel_list_tracker.sv
// bdel_list_tracker: watches both streams of the bounded double-ended list,
// predicts each result and compares it field by field; depends on bdel_pkg
`timescale 1ns / 1ps

module bdel_list_tracker import bdel_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int M_W      = ((READ_W + CNT_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_W-1:0]        m_tdata,
    input  logic [STS_W-1:0]      m_tuser,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [READ_W-1:0] word;
        logic [CNT_W-1:0]  count;
        status_t           status;
    } list_result_t;

    // list contents, head at index 0
    logic [READ_W-1:0] entries [$];
    list_result_t      pending_results [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // applies one command to the tracked list and returns the result it causes
    function automatic list_result_t apply_list_command(input cmd_t op,
                                                        input logic [READ_W-1:0] word,
                                                        input logic [POS_W-1:0] pos);
        list_result_t r;
        r.word   = '0;
        r.status = STS_OK;
        case (op)
            CMD_INS_HEAD, CMD_INS_TAIL:
                if (entries.size() >= CAPACITY)
                    r.status = STS_FULL;
                else if (op == CMD_INS_HEAD)
                    entries.push_front(word);
                else
                    entries.push_back(word);
            CMD_RM_HEAD:
                if (entries.size() == 0)
                    r.status = STS_EMPTY;
                else
                    void'(entries.pop_front());
            CMD_RM_TAIL:
                if (entries.size() == 0)
                    r.status = STS_EMPTY;
                else
                    void'(entries.pop_back());
            CMD_RD_HEAD:
                if (entries.size() == 0)
                    r.status = STS_EMPTY;
                else
                    r.word = entries[0];
            CMD_RD_TAIL:
                if (entries.size() == 0)
                    r.status = STS_EMPTY;
                else
                    r.word = entries[entries.size() - 1];
            CMD_RD_INDEX:
                if (entries.size() == 0)
                    r.status = STS_EMPTY;
                else if (int'(pos) >= entries.size())
                    r.status = STS_RANGE;
                else
                    r.word = entries[pos];
            default:
                ;
        endcase
        r.count = CNT_W'(entries.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        list_result_t seen;
        list_result_t want;
        if (!rst_n)
        begin
            entries.delete();
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.word   = m_tdata[READ_W-1:0];
                seen.count  = m_tdata[READ_W +: CNT_W];
                seen.status = status_t'(m_tuser);
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result with none pending: data %h count %0d %s",
                                              seen.word, seen.count, seen.status.name()));
                else
                begin
                    want = pending_results.pop_front();
                    if (seen.word !== want.word)
                        report_mismatch($sformatf("read_data %h, predicted %h",
                                                  seen.word, want.word));
                    if (seen.count !== want.count)
                        report_mismatch($sformatf("count %0d, predicted %0d",
                                                  seen.count, want.count));
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status %s, predicted %s",
                                                  seen.status.name(), want.status.name()));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_list_command(cmd_t'(s_tuser),
                                                             s_tdata[ENTRY_IN_W-1:0],
                                                             s_tdata[ENTRY_IN_W +: POS_W]));
            outstanding = pending_results.size();
        end
    end

endmodule

>>> verif/testbench.sv
// testbench: stimulus and verdict for bounded_double_ended_list_core
// depends on bdel_pkg, the core and bdel_list_tracker
`timescale 1ns / 1ps

module testbench;

    import bdel_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int M_W          = ((READ_W + CNT_W + 7) / 8) * 8;
    // run limit, with plenty of margin over the slowest run
    localparam int CYCLE_LIMIT  = 400000;
    // room for the back end and the request queue to empty, taken generously
    localparam int DRAIN_CYCLES = 40;
    // long receiver hold-off so the request queue fills and s_tready drops
    localparam int LONG_HOLD    = 300;

    // command mixes for the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } cmd_mix_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;     // entry_data[31:0], position[39:32]
    logic [CMD_W-1:0]      s_tuser;     // command[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_W-1:0]        m_tdata;     // read_data[31:0], count[40:32], zero fill
    logic [STS_W-1:0]      m_tuser;     // status[1:0]

    int mismatches;
    int outstanding;
    int cycle_cnt;
    // stimulus-side view of the fill level, used only to aim positions
    int level   = 0;
    // remaining requests of a no-idle stretch on each side
    int tx_calm = 0;
    int rx_calm = 0;

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bounded_double_ended_list_core #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (DEF_ENTRY_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // prediction and comparison live in the tracker
    bdel_list_tracker #(
        .CAPACITY (CAPACITY)
    ) tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // idle cycles before the next request, with occasional no-idle stretches
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // offers one request and waits until the core takes it
    // called right after a rising edge, returns right after one
    task automatic send_request(input cmd_t op, input logic [ENTRY_IN_W-1:0] word,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, word};
        s_tuser  <= op;
        @(posedge clk);
        while (!(s_tvalid && s_tready))
            @(posedge clk);
        // keep the fill level in step for position aiming
        if ((op == CMD_INS_HEAD || op == CMD_INS_TAIL) && level < CAPACITY)
            level++;
        else if ((op == CMD_RM_HEAD || op == CMD_RM_TAIL) && level > 0)
            level--;
    endtask

    // random requests with a command mix that drives the list towards full, towards empty or neither
    task automatic run_phase(input cmd_mix_t mix, input int n);
        int   pick;
        cmd_t op;
        logic [POS_W-1:0] pos;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                    if (pick < 40)      op = CMD_INS_HEAD;
                    else if (pick < 80) op = CMD_INS_TAIL;
                    else if (pick < 83) op = CMD_RM_HEAD;
                    else if (pick < 85) op = CMD_RM_TAIL;
                    else                op = cmd_t'($urandom_range(4, 7));
                MIX_DRAIN:
                    if (pick < 40)      op = CMD_RM_HEAD;
                    else if (pick < 80) op = CMD_RM_TAIL;
                    else if (pick < 83) op = CMD_INS_HEAD;
                    else if (pick < 85) op = CMD_INS_TAIL;
                    else                op = cmd_t'($urandom_range(4, 7));
                default:
                    op = cmd_t'($urandom_range(0, 7));
            endcase
            // indexed reads mostly land inside the list, the rest anywhere
            if (op == CMD_RD_INDEX && level > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, level - 1));
            else
                pos = POS_W'($urandom_range(0, 255));
            send_request(op, $urandom, pos);
        end
    endtask

    // result side: random stalls, no-idle stretches and two long hold-offs
    initial
    begin : result_side
        int gap;
        int taken;
        taken    = 0;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken == 200 || taken == 800)
                gap = LONG_HOLD;
            else
                gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
            taken++;
        end
    end

    // run limit
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_SIZE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: every command that can fail on empty
        send_request(CMD_SIZE,     32'h1234_5678, 8'd0);
        send_request(CMD_RM_HEAD,  32'hFFFF_FFFF, 8'd0);
        send_request(CMD_RM_TAIL,  32'h0000_0000, 8'd0);
        send_request(CMD_RD_HEAD,  32'h0000_0000, 8'd255);
        send_request(CMD_RD_TAIL,  32'h0000_0000, 8'd0);
        send_request(CMD_RD_INDEX, 32'h0000_0000, 8'd0);
        // extreme words at both ends
        send_request(CMD_INS_TAIL, 32'hFFFF_FFFF, 8'd0);
        send_request(CMD_INS_HEAD, 32'h0000_0000, 8'd255);
        send_request(CMD_INS_TAIL, 32'hA5A5_5A5A, 8'd0);
        send_request(CMD_RD_HEAD,  32'h0000_0000, 8'd0);
        send_request(CMD_RD_TAIL,  32'h0000_0000, 8'd0);
        send_request(CMD_RD_INDEX, 32'h0000_0000, 8'd1);
        // position equal to the count, then the largest position
        send_request(CMD_RD_INDEX, 32'h0000_0000, 8'd3);
        send_request(CMD_RD_INDEX, 32'hFFFF_FFFF, 8'd255);
        send_request(CMD_RD_INDEX, 32'h0000_0000, 8'd0);
        send_request(CMD_SIZE,     32'hFFFF_FFFF, 8'd255);
        // drain back to empty, reading in between
        send_request(CMD_RM_HEAD,  32'h0000_0000, 8'd0);
        send_request(CMD_RM_TAIL,  32'h0000_0000, 8'd0);
        send_request(CMD_RD_HEAD,  32'h0000_0000, 8'd0);
        send_request(CMD_RM_TAIL,  32'h0000_0000, 8'd0);
        send_request(CMD_RM_HEAD,  32'h0000_0000, 8'd0);

        // fill to capacity and beyond, drain past empty, wander, then fill again
        run_phase(MIX_FILL,  400);
        run_phase(MIX_DRAIN, 400);
        run_phase(MIX_EVEN,  280);
        run_phase(MIX_FILL,  200);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> bounded_double_ended_list_core.f
sv/bdel_pkg.sv
sv/bdel_front.sv
sv/bdel_queue.sv
sv/bdel_back.sv
sv/bounded_double_ended_list_core.sv
verif/bdel_list_tracker.sv
verif/testbench.sv
